@@ hdl/bpc_pkg.sv @@
// shared types and constants of the barometer compensation block
`timescale 1ns / 1ps
`default_nettype none
package bpc_pkg;

  // decoded calibration coefficients, raw codes straight from the packed bytes
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [7:0]  t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [7:0]  p3;
    logic [7:0]  p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [7:0]  p7;
    logic [7:0]  p8;
    logic [15:0] p9;
    logic [7:0]  p10;
    logic [7:0]  p11;
  } calib_t;

  localparam int unsigned OUT_FRAC_BITS_DEF = 8;
  localparam int unsigned RAW_W   = 24;
  localparam int unsigned PRESS_W = 25;
  localparam int unsigned TEMP_W  = 16;
  localparam int unsigned T_W     = 36;
  localparam int unsigned P_W     = 60;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 64;

  localparam int unsigned SEA_LEVEL_PA = 101325;
  localparam logic [PRESS_W-1:0] REF_PRESS_RESET = PRESS_W'(SEA_LEVEL_PA << 8);
  localparam logic signed [P_W-1:0] SEA_LEVEL_Q24 = P_W'(SEA_LEVEL_PA) << 24;
  localparam int CAL_OFFSET = 16384;

  localparam logic [1:0] REG_CALIB_LOW  = 2'd0;
  localparam logic [1:0] REG_CALIB_MID  = 2'd1;
  localparam logic [1:0] REG_CALIB_HIGH = 2'd2;
  localparam logic [1:0] REG_REF_PRESS  = 2'd3;

endpackage
`default_nettype wire

@@ hdl/bpc_if.sv @@
// valid/ready channel interfaces for samples and results
`timescale 1ns / 1ps
`default_nettype none
interface bpc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_pressure;
  logic [23:0] raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_out_if;
  logic               valid;
  logic               ready;
  logic [24:0]        pressure_pa;
  logic signed [15:0] temperature_c;
  logic               saturated;
  modport source (output valid, pressure_pa, temperature_c, saturated, input ready);
  modport sink (input valid, pressure_pa, temperature_c, saturated, output ready);
endinterface
`default_nettype wire

@@ hdl/baro_pressure_temp_compensation.sv @@
// top level of the barometer pressure and temperature compensation pipeline
// usage:
//   samples enter on in_if (raw_pressure, raw_temperature) and compensated words
//   leave on out_if (pressure_pa, temperature_c, saturated), both valid/ready
// - a word is taken when valid and ready are high at a rising clock edge
// - calibration bytes and reference pressure are written over the apb port,
//   registers at byte addresses 0, 8, 16, 24; write only while the pipe is empty
// - from acceptance to the result word on out_if a word passes through
//   3 temperature stages, 7 pressure stages and the output register
// - throughput is one word per cycle while out_if does not stall; the
//   multiplier chain is fully pipelined
// - a stall on out_if freezes every stage together, so in_if.ready drops the
//   same cycle and nothing is lost or repeated; the output register lets a new
//   word in while the previous result is being taken
// - reset clears all valid bits and loads the register defaults (zero
//   calibration, reference pressure 101325 Pa)
`timescale 1ns / 1ps
`default_nettype none
module baro_pressure_temp_compensation #(
  parameter int unsigned OUT_FRAC_BITS = bpc_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  bpc_in_if.sink                           in_if,
  bpc_out_if.source                        out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bpc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [bpc_pkg::DATA_W-1:0]  pwdata,
  output logic      [bpc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);

  // q24 to q(OUT_FRAC_BITS) is a plain floor shift
  localparam int unsigned SH = 24 - OUT_FRAC_BITS;
  localparam int TW = bpc_pkg::T_W;
  localparam int PW = bpc_pkg::P_W;

  bpc_pkg::calib_t cal;
  logic [bpc_pkg::PRESS_W-1:0] ref_press;

  // whole pipe advances when the output register is free or being drained
  logic en;
  logic out_valid_q;
  assign en          = ~out_valid_q | out_if.ready;
  assign in_if.ready = en;

  bpc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cal_o       (cal),
    .ref_press_o (ref_press)
  );

  logic                       tv;
  logic [bpc_pkg::RAW_W-1:0]  trp;
  logic signed [TW-1:0]       tt;

  bpc_temp u_temp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (en),
    .valid_i           (in_if.valid),
    .raw_pressure_i    (in_if.raw_pressure),
    .raw_temperature_i (in_if.raw_temperature),
    .cal_i             (cal),
    .valid_o           (tv),
    .rp_o              (trp),
    .t_o               (tt)
  );

  logic                 pv;
  logic signed [PW-1:0] pq24;
  logic signed [TW-1:0] tq24;

  bpc_press u_press (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (tv),
    .rp_i        (trp),
    .t_i         (tt),
    .cal_i       (cal),
    .ref_press_i (ref_press),
    .valid_o     (pv),
    .p_o         (pq24),
    .t_o         (tq24)
  );

  // output scaling and clipping
  logic signed [PW-1:0] po_w;
  logic signed [TW-1:0] to_w;
  logic po_neg, po_big, to_hi, to_lo;
  logic [bpc_pkg::PRESS_W-1:0] po_d, pressure_q;
  logic [bpc_pkg::TEMP_W-1:0]  to_d, temp_q;
  logic sat_d, sat_q;

  assign po_w   = pq24 >>> SH;
  assign to_w   = tq24 >>> SH;
  assign po_neg = po_w[PW-1];
  assign po_big = ~po_w[PW-1] & (|po_w[PW-2:bpc_pkg::PRESS_W]);
  assign to_hi  = ~to_w[TW-1] & (|to_w[TW-2:bpc_pkg::TEMP_W-1]);
  assign to_lo  = to_w[TW-1] & ~(&to_w[TW-2:bpc_pkg::TEMP_W-1]);

  always_comb begin
    if (po_neg) begin
      po_d = '0;
    end else if (po_big) begin
      po_d = '1;
    end else begin
      po_d = po_w[bpc_pkg::PRESS_W-1:0];
    end
    if (to_hi) begin
      to_d = {1'b0, {(bpc_pkg::TEMP_W-1){1'b1}}};
    end else if (to_lo) begin
      to_d = {1'b1, {(bpc_pkg::TEMP_W-1){1'b0}}};
    end else begin
      to_d = to_w[bpc_pkg::TEMP_W-1:0];
    end
    sat_d = po_neg | po_big | to_hi | to_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= pv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && pv) begin
      pressure_q <= po_d;
      temp_q     <= to_d;
      sat_q      <= sat_d;
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.pressure_pa   = pressure_q;
  assign out_if.temperature_c = $signed(temp_q);
  assign out_if.saturated     = sat_q;

endmodule
`default_nettype wire

@@ hdl/bpc_cfg.sv @@
// apb register file and calibration byte decode
`timescale 1ns / 1ps
`default_nettype none
module bpc_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [bpc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [bpc_pkg::DATA_W-1:0]   pwdata,
  output logic      [bpc_pkg::DATA_W-1:0]   prdata,
  output logic                              pready,
  output bpc_pkg::calib_t                   cal_o,
  output logic      [bpc_pkg::PRESS_W-1:0]  ref_press_o
);

  logic [63:0] cal_low_q, cal_mid_q;
  logic [39:0] cal_high_q;
  logic [bpc_pkg::PRESS_W-1:0] ref_q;
  logic [1:0] idx;
  logic wr;
  logic [167:0] b;

  assign idx    = paddr[4:3];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_low_q  <= '0;
      cal_mid_q  <= '0;
      cal_high_q <= '0;
      ref_q      <= bpc_pkg::REF_PRESS_RESET;
    end else if (wr) begin
      case (idx)
        bpc_pkg::REG_CALIB_LOW:  cal_low_q  <= pwdata;
        bpc_pkg::REG_CALIB_MID:  cal_mid_q  <= pwdata;
        bpc_pkg::REG_CALIB_HIGH: cal_high_q <= pwdata[39:0];
        bpc_pkg::REG_REF_PRESS:  ref_q      <= pwdata[bpc_pkg::PRESS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bpc_pkg::REG_CALIB_LOW:  prdata = cal_low_q;
      bpc_pkg::REG_CALIB_MID:  prdata = cal_mid_q;
      bpc_pkg::REG_CALIB_HIGH: prdata = {24'h0, cal_high_q};
      bpc_pkg::REG_REF_PRESS:  prdata = {39'h0, ref_q};
      default:                 prdata = '0;
    endcase
  end

  // byte i sits at b[8i +: 8]
  assign b = {cal_high_q, cal_mid_q, cal_low_q};

  assign cal_o.t1  = b[15:0];
  assign cal_o.t2  = b[31:16];
  assign cal_o.t3  = b[39:32];
  assign cal_o.p1  = b[55:40];
  assign cal_o.p2  = b[71:56];
  assign cal_o.p3  = b[79:72];
  assign cal_o.p4  = b[87:80];
  assign cal_o.p5  = b[103:88];
  assign cal_o.p6  = b[119:104];
  assign cal_o.p7  = b[127:120];
  assign cal_o.p8  = b[135:128];
  assign cal_o.p9  = b[151:136];
  assign cal_o.p10 = b[159:152];
  assign cal_o.p11 = b[167:160];
  assign ref_press_o = ref_q;

endmodule
`default_nettype wire

@@ hdl/bpc_temp.sv @@
// three stage temperature polynomial, q24 result
`timescale 1ns / 1ps
`default_nettype none
module bpc_temp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic        [bpc_pkg::RAW_W-1:0]  raw_pressure_i,
  input  wire logic        [bpc_pkg::RAW_W-1:0]  raw_temperature_i,
  input  wire bpc_pkg::calib_t                   cal_i,
  output logic                                   valid_o,
  output logic             [bpc_pkg::RAW_W-1:0]  rp_o,
  output logic signed      [bpc_pkg::T_W-1:0]    t_o
);

  logic [2:0] v_q;
  logic [23:0] rp1_q, rp2_q, rp3_q;
  logic signed [25:0] td_d, td_q;
  logic signed [42:0] a_d, a_q;
  logic signed [51:0] sq_d, sq_q;
  logic signed [59:0] m3;
  logic signed [60:0] s3;
  logic signed [bpc_pkg::T_W-1:0] t_q;

  assign td_d = $signed({2'b00, raw_temperature_i}) - $signed({2'b00, cal_i.t1, 8'h00});
  assign a_d  = td_q * $signed({1'b0, cal_i.t2});
  assign sq_d = td_q * td_q;
  assign m3   = sq_q * $signed(cal_i.t3);
  assign s3   = (a_q >>> 6) + (m3 >>> 24);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rp1_q <= raw_pressure_i;
      td_q  <= td_d;
      rp2_q <= rp1_q;
      a_q   <= a_d;
      sq_q  <= sq_d;
      rp3_q <= rp2_q;
      t_q   <= s3[bpc_pkg::T_W-1:0];
    end
  end

  assign valid_o = v_q[2];
  assign rp_o    = rp3_q;
  assign t_o     = t_q;

endmodule
`default_nettype wire

@@ hdl/bpc_press.sv @@
// seven stage pressure polynomial, q24 pascal result
`timescale 1ns / 1ps
`default_nettype none
module bpc_press (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic        [bpc_pkg::RAW_W-1:0]  rp_i,
  input  wire logic signed [bpc_pkg::T_W-1:0]    t_i,
  input  wire bpc_pkg::calib_t                   cal_i,
  input  wire logic        [bpc_pkg::PRESS_W-1:0] ref_press_i,
  output logic                                   valid_o,
  output logic signed      [bpc_pkg::P_W-1:0]    p_o,
  output logic signed      [bpc_pkg::T_W-1:0]    t_o
);

  localparam int TW = bpc_pkg::T_W;
  localparam int PW = bpc_pkg::P_W;

  logic [6:0] v_q;

  // stage 4: t^2, first order temperature products, pp
  logic signed [71:0] tt, tt_sh;
  logic signed [52:0] m6, m6_sh;
  logic signed [17:0] p2c;
  logic signed [53:0] m2, m2_sh;
  logic signed [43:0] m10;
  logic signed [44:0] k_d;
  logic signed [TW-1:0] t4_q;
  logic [23:0] rp4_q;
  logic signed [47:0] t2_4_q;
  logic signed [46:0] p6s_4_q;
  logic signed [48:0] p2s_4_q;
  logic signed [44:0] k_4_q;
  logic [47:0] pp_4_q;

  assign tt    = t_i * t_i;
  assign tt_sh = tt >>> 24;
  assign m6    = t_i * $signed({1'b0, cal_i.p6});
  assign m6_sh = m6 >>> 6;
  assign p2c   = $signed({{2{cal_i.p2[15]}}, cal_i.p2}) - 18'(bpc_pkg::CAL_OFFSET);
  assign m2    = t_i * p2c;
  assign m2_sh = m2 >>> 5;
  assign m10   = t_i * $signed(cal_i.p10);
  assign k_d   = ($signed(cal_i.p9) <<< 24) + m10;

  // stage 5: t^3 partials, t^2 products, pp*rp partials
  logic signed [59:0] mh5_d;
  logic signed [60:0] ml5_d;
  logic signed [55:0] m7, m7_sh, m3p, m3p_sh;
  logic [47:0] pph5_d, ppl5_d;
  logic signed [59:0] mh5_q;
  logic signed [60:0] ml5_q;
  logic signed [47:0] p7s_5_q, p3s_5_q;
  logic [47:0] pph5_q, ppl5_q, pp_5_q;
  logic signed [46:0] p6s_5_q;
  logic signed [48:0] p2s_5_q;
  logic signed [44:0] k_5_q;
  logic signed [TW-1:0] t5_q;
  logic [23:0] rp5_q;

  assign mh5_d  = $signed(t2_4_q[47:24]) * t4_q;
  assign ml5_d  = $signed({1'b0, t2_4_q[23:0]}) * t4_q;
  assign m7     = t2_4_q * $signed(cal_i.p7);
  assign m7_sh  = m7 >>> 8;
  assign m3p    = t2_4_q * $signed(cal_i.p3);
  assign m3p_sh = m3p >>> 8;
  assign pph5_d = pp_4_q[47:24] * rp4_q;
  assign ppl5_d = pp_4_q[23:0] * rp4_q;

  // stage 6: t^3, pp*rp/2^32, pp*k partials
  logic signed [60:0] t3w;
  logic [72:0] ppsum;
  logic signed [69:0] mkh_d, mkl_d;
  logic signed [58:0] t3_6_q;
  logic [39:0] ppr_6_q;
  logic signed [69:0] mkh_6_q, mkl_6_q;
  logic signed [47:0] p7s_6_q, p3s_6_q;
  logic signed [46:0] p6s_6_q;
  logic signed [48:0] p2s_6_q;
  logic signed [TW-1:0] t6_q;
  logic [23:0] rp6_q;

  assign t3w   = mh5_q + (ml5_q >>> 24);
  assign ppsum = {pph5_q, 24'h0} + ppl5_q;
  assign mkh_d = $signed({1'b0, pp_5_q[47:24]}) * k_5_q;
  assign mkl_d = $signed({1'b0, pp_5_q[23:0]}) * k_5_q;

  // stage 7: t^3 products, third order pressure term, pp*k/2^48
  logic signed [66:0] m8, m8_sh, m4, m4_sh;
  logic signed [48:0] m11, m11_sh;
  logic signed [70:0] oa, oa_sh;
  logic signed [51:0] p8s_7_q;
  logic signed [53:0] p4s_7_q;
  logic signed [39:0] o3b_7_q;
  logic signed [46:0] o3a_7_q;
  logic signed [47:0] p7s_7_q, p3s_7_q;
  logic signed [46:0] p6s_7_q;
  logic signed [48:0] p2s_7_q;
  logic signed [TW-1:0] t7_q;
  logic [23:0] rp7_q;

  assign m8     = t3_6_q * $signed(cal_i.p8);
  assign m8_sh  = m8 >>> 15;
  assign m4     = t3_6_q * $signed(cal_i.p4);
  assign m4_sh  = m4 >>> 13;
  assign m11    = $signed({1'b0, ppr_6_q}) * $signed(cal_i.p11);
  assign m11_sh = m11 >>> 9;
  assign oa     = mkh_6_q + (mkl_6_q >>> 24);
  assign oa_sh  = oa >>> 24;

  // stage 8: offset, sensitivity bracket, second/third order sum
  logic signed [17:0] p1c;
  logic signed [55:0] o1_d, sens_d, o3_d;
  logic signed [55:0] o1_8_q, sens_8_q, o3_8_q;
  logic signed [TW-1:0] t8_q;
  logic [23:0] rp8_q;

  assign p1c    = $signed({{2{cal_i.p1[15]}}, cal_i.p1}) - 18'(bpc_pkg::CAL_OFFSET);
  assign o1_d   = ($signed({1'b0, cal_i.p5}) <<< 27) + p6s_7_q + p7s_7_q + p8s_7_q;
  assign sens_d = (p1c <<< 28) + p2s_7_q + p3s_7_q + p4s_7_q;
  assign o3_d   = o3a_7_q + o3b_7_q;

  // stage 9: sensitivity times raw pressure, split in two partials
  logic signed [52:0] sh_d;
  logic signed [53:0] sl_d;
  logic signed [52:0] sh_9_q;
  logic signed [53:0] sl_9_q;
  logic signed [55:0] o1_9_q, o3_9_q;
  logic signed [TW-1:0] t9_q;

  assign sh_d = $signed(sens_8_q[55:28]) * $signed({1'b0, rp8_q});
  assign sl_d = $signed({1'b0, sens_8_q[27:0]}) * $signed({1'b0, rp8_q});

  // stage 10: final pressure sum
  logic signed [PW-1:0] o2, p_d, p_q;
  logic signed [TW-1:0] t10_q;

  assign o2  = (sh_9_q <<< 4) + (sl_9_q >>> 24);
  assign p_d = o1_9_q + o2 + o3_9_q - ($signed({1'b0, ref_press_i}) <<< 16)
             + bpc_pkg::SEA_LEVEL_Q24;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t4_q    <= t_i;
      rp4_q   <= rp_i;
      t2_4_q  <= tt_sh[47:0];
      p6s_4_q <= m6_sh[46:0];
      p2s_4_q <= m2_sh[48:0];
      k_4_q   <= k_d;
      pp_4_q  <= rp_i * rp_i;

      mh5_q   <= mh5_d;
      ml5_q   <= ml5_d;
      p7s_5_q <= m7_sh[47:0];
      p3s_5_q <= m3p_sh[47:0];
      pph5_q  <= pph5_d;
      ppl5_q  <= ppl5_d;
      pp_5_q  <= pp_4_q;
      p6s_5_q <= p6s_4_q;
      p2s_5_q <= p2s_4_q;
      k_5_q   <= k_4_q;
      t5_q    <= t4_q;
      rp5_q   <= rp4_q;

      t3_6_q  <= t3w[58:0];
      ppr_6_q <= ppsum[71:32];
      mkh_6_q <= mkh_d;
      mkl_6_q <= mkl_d;
      p7s_6_q <= p7s_5_q;
      p3s_6_q <= p3s_5_q;
      p6s_6_q <= p6s_5_q;
      p2s_6_q <= p2s_5_q;
      t6_q    <= t5_q;
      rp6_q   <= rp5_q;

      p8s_7_q <= m8_sh[51:0];
      p4s_7_q <= m4_sh[53:0];
      o3b_7_q <= m11_sh[39:0];
      o3a_7_q <= oa_sh[46:0];
      p7s_7_q <= p7s_6_q;
      p3s_7_q <= p3s_6_q;
      p6s_7_q <= p6s_6_q;
      p2s_7_q <= p2s_6_q;
      t7_q    <= t6_q;
      rp7_q   <= rp6_q;

      o1_8_q   <= o1_d;
      sens_8_q <= sens_d;
      o3_8_q   <= o3_d;
      t8_q     <= t7_q;
      rp8_q    <= rp7_q;

      sh_9_q <= sh_d;
      sl_9_q <= sl_d;
      o1_9_q <= o1_8_q;
      o3_9_q <= o3_8_q;
      t9_q   <= t8_q;

      p_q   <= p_d;
      t10_q <= t9_q;
    end
  end

  assign valid_o = v_q[6];
  assign p_o     = p_q;
  assign t_o     = t10_q;

endmodule
`default_nettype wire

@@ tb/sv/baro_pressure_temp_compensation_tb.sv @@
// testbench for the barometer compensation block: scoreboard, stimulus and checks
`timescale 1ns / 1ps
`default_nettype none
module baro_pressure_temp_compensation_tb;

  // one compensated word as it leaves the block
  typedef struct {
    logic [bpc_pkg::PRESS_W-1:0]       press;
    logic signed [bpc_pkg::TEMP_W-1:0] temp;
    logic                              sat;
  } comp_word_t;

  // keeps its own copy of the calibration registers, predicts each word and
  // matches the words coming out in order
  class comp_scoreboard;
    logic [63:0]                 cal_lo, cal_mid;
    logic [39:0]                 cal_hi;
    logic [bpc_pkg::PRESS_W-1:0] ref_pa;
    comp_word_t                  expected_words[$];
    int unsigned                 errors, checked, clipped;

    function void set_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        bpc_pkg::REG_CALIB_LOW:  cal_lo = value;
        bpc_pkg::REG_CALIB_MID:  cal_mid = value;
        bpc_pkg::REG_CALIB_HIGH: cal_hi = value[39:0];
        bpc_pkg::REG_REF_PRESS:  ref_pa = value[bpc_pkg::PRESS_W-1:0];
        default: ;
      endcase
    endfunction

    function longint cbyte(int i);
      logic [167:0] all_bytes;
      all_bytes = {cal_hi, cal_mid, cal_lo};
      return longint'(all_bytes[8*i +: 8]);
    endfunction

    function longint u16(int i);
      return cbyte(i) | (cbyte(i + 1) << 8);
    endfunction

    function longint s16(int i);
      longint u;
      u = u16(i);
      return (u >= 32768) ? u - 65536 : u;
    endfunction

    function longint s8(int i);
      longint u;
      u = cbyte(i);
      return (u >= 128) ? u - 256 : u;
    endfunction

    // exact product, floor shift, clipped to 64-bit signed range
    function longint mshift(longint a, longint b, int sh);
      logic signed [127:0] xa, xb, pr, lim_hi, lim_lo;
      xa = a;
      xb = b;
      lim_hi = 64'sh7fff_ffff_ffff_ffff;
      lim_lo = -lim_hi - 1;
      pr = (xa * xb) >>> sh;
      if (pr > lim_hi) return lim_hi[63:0];
      if (pr < lim_lo) return lim_lo[63:0];
      return pr[63:0];
    endfunction

    function comp_word_t compensate(logic [bpc_pkg::RAW_W-1:0] raw_p,
                                    logic [bpc_pkg::RAW_W-1:0] raw_t);
      longint rp, td, t, t2, t3, o1, sens, o2, pp, k, o3, p, po, tq;
      comp_word_t w;
      rp = longint'(raw_p);
      td = longint'(raw_t) - (u16(0) << 8);
      t  = mshift(td, u16(2), 6) + mshift(td * td, s8(4), 24);
      t2 = mshift(t, t, 24);
      t3 = mshift(t2, t, 24);
      // offset part of the pressure polynomial
      o1 = (u16(11) << 27) + mshift(t, u16(13), 6) + mshift(t2, s8(15), 8)
         + mshift(t3, s8(16), 15);
      // sensitivity bracket, scaled by the raw count
      sens = (s16(5) - bpc_pkg::CAL_OFFSET) * (longint'(1) << 28)
           + mshift(t, s16(7) - bpc_pkg::CAL_OFFSET, 5) + mshift(t2, s8(9), 8)
           + mshift(t3, s8(10), 13);
      o2 = mshift(sens, rp, 24);
      pp = rp * rp;
      k  = s16(17) * (longint'(1) << 24) + s8(19) * t;
      o3 = mshift(pp, k, 48) + mshift(mshift(pp, rp, 32), s8(20), 9);
      p  = o1 + o2 + o3 - (longint'(ref_pa) << 16)
         + (longint'(bpc_pkg::SEA_LEVEL_PA) << 24);
      po = mshift(p, 1, 24 - bpc_pkg::OUT_FRAC_BITS_DEF);
      tq = mshift(t, 1, 24 - bpc_pkg::OUT_FRAC_BITS_DEF);
      w.sat = 1'b0;
      if (po < 0) begin
        po = 0;
        w.sat = 1'b1;
      end
      if (po > 33554431) begin
        po = 33554431;
        w.sat = 1'b1;
      end
      if (tq < -32768) begin
        tq = -32768;
        w.sat = 1'b1;
      end
      if (tq > 32767) begin
        tq = 32767;
        w.sat = 1'b1;
      end
      w.press = po[bpc_pkg::PRESS_W-1:0];
      w.temp  = tq[bpc_pkg::TEMP_W-1:0];
      return w;
    endfunction

    function void note_sample(logic [bpc_pkg::RAW_W-1:0] raw_p,
                              logic [bpc_pkg::RAW_W-1:0] raw_t);
      comp_word_t w;
      w = compensate(raw_p, raw_t);
      if (w.sat) clipped++;
      expected_words.push_back(w);
    endfunction

    function void check_word(comp_word_t got);
      comp_word_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word p=%h t=%h s=%b", $time, got.press, got.temp,
                 got.sat);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      checked++;
      if (got.press !== want.press) begin
        $display("%0t: pressure_pa expected %h actual %h", $time, want.press, got.press);
        errors++;
      end
      if (got.temp !== want.temp) begin
        $display("%0t: temperature_c expected %h actual %h", $time, want.temp, got.temp);
        errors++;
      end
      if (got.sat !== want.sat) begin
        $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
        errors++;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         psel, penable, pwrite;
  logic [bpc_pkg::ADDR_W-1:0]   paddr;
  logic [bpc_pkg::DATA_W-1:0]   pwdata;
  logic [bpc_pkg::DATA_W-1:0]   prdata;
  logic                         pready;

  bpc_in_if  in_bus();
  bpc_out_if out_bus();

  comp_scoreboard sb = new();
  bit send_idle_en, recv_idle_en;
  int unsigned stall_left;
  int unsigned sample_cnt;

  always #2 clk_i = ~clk_i;

  baro_pressure_temp_compensation DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_bus),
    .out_if  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // result side: check each taken word, then decide whether to stall next cycle
  initial begin
    out_bus.ready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_bus.valid && out_bus.ready)
        sb.check_word('{out_bus.pressure_pa, out_bus.temperature_c, out_bus.saturated});
      if (stall_left > 0) begin
        stall_left--;
        out_bus.ready <= 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        // start a stall burst of random length, counted down in stall_left
        stall_left = $urandom_range(0, 3);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // setup cycle then access cycle; the register takes the data on the access edge
  task automatic apb_write(logic [1:0] idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // present one sample, maybe after an idle burst, and hold it until taken
  task automatic send_sample(logic [bpc_pkg::RAW_W-1:0] raw_p,
                             logic [bpc_pkg::RAW_W-1:0] raw_t);
    if (send_idle_en && $urandom_range(0, 4) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_bus.valid           <= 1'b1;
    in_bus.raw_pressure    <= raw_p;
    in_bus.raw_temperature <= raw_t;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_sample(raw_p, raw_t);
    sample_cnt++;
  endtask

  // the last sample was taken at this edge, so valid drops right here
  task automatic drain_pipe();
    in_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    // leave margin before touching the registers
    repeat (16) @(posedge clk_i);
  endtask

  // plausible calibration around typical sensor coefficients, fully random bytes, or all-ones bytes
  task automatic load_calibration(int kind);
    logic [7:0]  cb[21];
    logic [167:0] packed_cal;
    logic [15:0] v16;
    if (kind == 0) begin
      for (int i = 0; i < 21; i++) cb[i] = 8'($urandom);
      v16 = 16'($urandom_range(26000, 29000));  {cb[1], cb[0]} = v16;
      v16 = 16'($urandom_range(17000, 21000));  {cb[3], cb[2]} = v16;
      cb[4] = 8'($urandom_range(0, 14) - 7);
      v16 = 16'($urandom_range(12000, 20000));  {cb[6], cb[5]} = v16;
      v16 = 16'($urandom_range(14000, 19000));  {cb[8], cb[7]} = v16;
      cb[9] = 8'($urandom_range(0, 20) - 10);
      cb[10] = 8'($urandom_range(0, 20) - 10);
      v16 = 16'($urandom_range(15000, 22000));  {cb[12], cb[11]} = v16;
      v16 = 16'($urandom_range(18000, 26000));  {cb[14], cb[13]} = v16;
      cb[15] = 8'($urandom_range(0, 20) - 10);
      cb[16] = 8'($urandom_range(0, 20) - 10);
      cb[19] = 8'($urandom_range(0, 40) - 20);
      cb[20] = 8'($urandom_range(0, 60) - 30);
    end else begin
      for (int i = 0; i < 21; i++) cb[i] = (kind == 2) ? 8'hff : 8'($urandom);
    end
    for (int i = 0; i < 21; i++) packed_cal[8*i +: 8] = cb[i];
    // upper unused bits of the short high register carry junk on purpose
    apb_write(bpc_pkg::REG_CALIB_LOW, packed_cal[63:0]);
    apb_write(bpc_pkg::REG_CALIB_MID, packed_cal[127:64]);
    apb_write(bpc_pkg::REG_CALIB_HIGH,
              {$urandom, $urandom} & ~64'hff_ffff_ffff | packed_cal[167:128]);
  endtask

  task automatic send_random(int kind, int count);
    logic [bpc_pkg::RAW_W-1:0] rp, rt;
    for (int n = 0; n < count; n++) begin
      rp = 24'($urandom);
      rt = 24'($urandom);
      if (kind == 0 && $urandom_range(0, 9) != 0) begin
        rp = 24'($urandom_range(4000000, 9000000));
        rt = 24'($urandom_range(7000000, 9500000));
      end
      send_sample(rp, rt);
      // halfway through a typical run without idle gaps, hold off until the pipe has emptied
      if (n == count / 2 && kind == 0 && !send_idle_en) begin
        in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int kind;
    rst_ni                  <= 1'b0;
    psel                    <= 1'b0;
    penable                 <= 1'b0;
    pwrite                  <= 1'b0;
    paddr                   <= '0;
    pwdata                  <= '0;
    in_bus.valid            <= 1'b0;
    in_bus.raw_pressure     <= '0;
    in_bus.raw_temperature  <= '0;
    sb.cal_lo = '0;
    sb.cal_mid = '0;
    sb.cal_hi = '0;
    sb.ref_pa = bpc_pkg::REF_PRESS_RESET;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // register defaults: zero calibration, raw extremes
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample('0, '1);
    send_sample('1, '0);
    send_sample(24'h800000, 24'h7fffff);
    drain_pipe();

    // typical calibration: nominal readings plus extremes
    load_calibration(0);
    apb_write(bpc_pkg::REG_REF_PRESS, 64'(bpc_pkg::REF_PRESS_RESET));
    send_sample(24'd6500000, 24'd8400000);
    send_sample(24'd6500000, 24'd0);
    send_sample(24'd6500000, '1);
    send_sample('0, 24'd8400000);
    send_sample('1, 24'd8400000);
    send_sample('1, '1);
    send_sample(24'd1, 24'd1);
    drain_pipe();

    // every calibration byte at its top value, reference pressure at both ends
    load_calibration(2);
    apb_write(bpc_pkg::REG_REF_PRESS, '1);
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample(24'd6500000, 24'd8400000);
    drain_pipe();
    apb_write(bpc_pkg::REG_REF_PRESS, 64'h0);
    send_sample('0, '0);
    send_sample('1, '1);
    send_sample(24'd6500000, 24'd8400000);
    drain_pipe();

    // random phases, typical calibration most of the time
    for (int ph = 0; ph < 8; ph++) begin
      kind = (ph % 3 == 1) ? 1 : 0;
      if (ph == 7) begin
        kind = 0;
        send_idle_en = 1'b0;
        recv_idle_en = 1'b0;
      end
      load_calibration(kind);
      case (ph % 4)
        0: apb_write(bpc_pkg::REG_REF_PRESS, {$urandom, $urandom});
        1: apb_write(bpc_pkg::REG_REF_PRESS, 64'(bpc_pkg::REF_PRESS_RESET));
        2: apb_write(bpc_pkg::REG_REF_PRESS, 64'($urandom_range(20000000, 27000000)));
        default: apb_write(bpc_pkg::REG_REF_PRESS, '1);
      endcase
      send_random(kind, 135);
      drain_pipe();
    end

    $display("covered %0d samples, %0d words checked, %0d clipped, %0d mismatches",
             sample_cnt, sb.checked, sb.clipped, sb.errors);
    $display("calibration: defaults, all-ones bytes, typical and random sets");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
